FILE: rtl/core/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants for the resistance trim search block.
// ----------------------------------------------------------------------------
package rts_pkg;

	localparam int MEAS_W = 24;
	localparam int TOL_W  = 16;
	localparam int CNT_W  = 5;
	localparam int TRIM_W = 16;
	localparam int EXP_W  = 4;
	localparam int DCNT_W = 16;
	localparam int MATCH_W = 4;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [1:0] REG_WIDE_MODE = 2'd0;
	localparam logic [1:0] REG_TARGET    = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;
	localparam logic [1:0] REG_SAMPLES   = 2'd3;

	localparam logic [MEAS_W-1:0] TARGET_RST = 24'd500000;
	localparam logic [TOL_W-1:0]  TOL_RST    = 16'd100;
	localparam logic [CNT_W-1:0]  CNT_RST    = 5'd1;

	localparam logic signed [TRIM_W-1:0] RAIL_HI_NARROW = 16'sd127;
	localparam logic signed [TRIM_W-1:0] RAIL_LO_NARROW = -16'sd128;
	localparam logic signed [TRIM_W-1:0] RAIL_HI_WIDE   = 16'sd32767;
	localparam logic signed [TRIM_W-1:0] RAIL_LO_WIDE   = -16'sd32768;

	localparam logic [DCNT_W:0] LIMIT_NARROW = 17'h00080;
	localparam logic [DCNT_W:0] LIMIT_WIDE   = 17'h08000;

	localparam logic [EXP_W-1:0]   EXP_WIDE_INIT = 4'd9;
	localparam logic [MATCH_W-1:0] MATCH_LAST    = 4'd9;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_CONVERGED,
		ST_RAIL,
		ST_LIMIT
	} status_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef struct packed {
		logic              wide_mode;
		logic [MEAS_W-1:0] target;
		logic [TOL_W-1:0]  tol;
		logic [CNT_W-1:0]  sample_count;
	} cfg_t;

	typedef struct packed {
		logic              command;
		logic [MEAS_W-1:0] meas;
	} item_t;

	typedef struct packed {
		logic                     done_res;
		status_t                  status;
		logic signed [TRIM_W-1:0] trim_value;
	} res_t;

endpackage

FILE: rtl/core/rts_cfg.sv
// ----------------------------------------------------------------------------
// rts_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module rts_cfg import rts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_mode    <= 1'b0;
			cfg_q.target       <= TARGET_RST;
			cfg_q.tol          <= TOL_RST;
			cfg_q.sample_count <= CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDE_MODE: cfg_q.wide_mode    <= cfg_data[0];
				REG_TARGET:    cfg_q.target       <= cfg_data[MEAS_W-1:0];
				REG_TOLERANCE: cfg_q.tol          <= cfg_data[TOL_W-1:0];
				REG_SAMPLES:   cfg_q.sample_count <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

endmodule

FILE: rtl/core/rts_core.sv
// ----------------------------------------------------------------------------
// rts_core
// Search state and the per-beat accumulate / decide / step logic.
// ----------------------------------------------------------------------------
module rts_core import rts_pkg::*; #(
	parameter int MAX_AVERAGE = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam int CW = $clog2(MAX_AVERAGE + 1);
	localparam int SW = MEAS_W + $clog2(MAX_AVERAGE);
	localparam int PW = MEAS_W + 2 + CW;

	logic signed [TRIM_W-1:0] trim_q, trim_d;
	logic [EXP_W-1:0]         exp_q, exp_d;
	dir_t                     dir_q, dir_d;
	logic [MATCH_W-1:0]       match_q, match_d;
	logic [DCNT_W-1:0]        dcnt_q, dcnt_d;
	logic [SW-1:0]            sum_q, sum_d;
	logic [CW-1:0]            taken_q, taken_d;
	logic                     fin_q, fin_d;
	status_t                  end_q, end_d;

	logic [CW-1:0]            need;
	logic [CW-1:0]            taken_new;
	logic [SW-1:0]            sum_new;
	logic signed [MEAS_W:0]   lo_base;
	logic [MEAS_W:0]          hi_base;
	logic signed [PW-1:0]     lo_prod, hi_prod, s_ext;
	logic                     hit, too_high;
	logic signed [TRIM_W+1:0] step, trim_x, next_x, rail_hi_x, rail_lo_x;
	logic [DCNT_W-1:0]        dcnt_new;
	logic [DCNT_W:0]          limit;

	always_comb begin
		if (cfg.sample_count == '0) begin
			need = CW'(1);
		end else if (32'(cfg.sample_count) > MAX_AVERAGE) begin
			need = CW'(MAX_AVERAGE);
		end else begin
			need = CW'(cfg.sample_count);
		end
	end

	assign taken_new = taken_q + CW'(1);
	assign sum_new   = sum_q + SW'(item.meas);

	assign lo_base = $signed({1'b0, cfg.target}) - $signed({{(MEAS_W-TOL_W+1){1'b0}}, cfg.tol});
	assign hi_base = {1'b0, cfg.target} + (MEAS_W+1)'(cfg.tol);
	assign lo_prod = PW'(lo_base) * $signed(PW'(taken_new));
	assign hi_prod = $signed(PW'(hi_base)) * $signed(PW'(taken_new));
	assign s_ext   = $signed(PW'(sum_new));

	assign hit      = (s_ext >= lo_prod) && (s_ext <= hi_prod);
	assign too_high = s_ext > hi_prod;

	assign step      = (TRIM_W+2)'(1) <<< exp_q;
	assign trim_x    = (TRIM_W+2)'(trim_q);
	assign rail_hi_x = (TRIM_W+2)'(cfg.wide_mode ? RAIL_HI_WIDE : RAIL_HI_NARROW);
	assign rail_lo_x = (TRIM_W+2)'(cfg.wide_mode ? RAIL_LO_WIDE : RAIL_LO_NARROW);
	assign limit     = cfg.wide_mode ? LIMIT_WIDE : LIMIT_NARROW;
	assign dcnt_new  = dcnt_q + DCNT_W'(1);

	always_comb begin
		if (hit) begin
			next_x = trim_x;
		end else if (too_high) begin
			next_x = trim_x - step;
		end else begin
			next_x = trim_x + step;
		end
	end

	always_comb begin
		trim_d  = trim_q;
		exp_d   = exp_q;
		dir_d   = dir_q;
		match_d = match_q;
		dcnt_d  = dcnt_q;
		sum_d   = sum_q;
		taken_d = taken_q;
		fin_d   = fin_q;
		end_d   = end_q;
		if (fire) begin
			if (item.command == CMD_START) begin
				trim_d  = '0;
				exp_d   = cfg.wide_mode ? EXP_WIDE_INIT : '0;
				dir_d   = DIR_NONE;
				match_d = '0;
				dcnt_d  = '0;
				sum_d   = '0;
				taken_d = '0;
				fin_d   = 1'b0;
				end_d   = ST_RUN;
			end else if (!fin_q) begin
				sum_d   = sum_new;
				taken_d = taken_new;
				if (taken_new >= need) begin
					sum_d   = '0;
					taken_d = '0;
					dcnt_d  = dcnt_new;
					if (hit && match_q > MATCH_LAST) begin
						fin_d = 1'b1;
						end_d = ST_CONVERGED;
					end else begin
						if (hit) begin
							match_d = match_q + MATCH_W'(1);
						end else if (too_high) begin
							if (dir_q == DIR_UP && exp_q != '0) begin
								exp_d = exp_q - EXP_W'(1);
							end
							dir_d = DIR_DOWN;
						end else begin
							if (dir_q == DIR_DOWN && exp_q != '0) begin
								exp_d = exp_q - EXP_W'(1);
							end
							dir_d = DIR_UP;
						end
						if (next_x >= rail_hi_x || next_x <= rail_lo_x) begin
							trim_d = rail_hi_x[TRIM_W-1:0];
							fin_d  = 1'b1;
							end_d  = ST_RAIL;
						end else begin
							trim_d = next_x[TRIM_W-1:0];
							if ({1'b0, dcnt_new} >= limit) begin
								fin_d = 1'b1;
								end_d = ST_LIMIT;
							end
						end
					end
				end
			end
		end
	end

	assign res.trim_value = trim_d;
	assign res.status     = fin_d ? end_d : ST_RUN;
	assign res.done_res   = fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q  <= '0;
			exp_q   <= '0;
			dir_q   <= DIR_NONE;
			match_q <= '0;
			dcnt_q  <= '0;
			sum_q   <= '0;
			taken_q <= '0;
			fin_q   <= 1'b0;
			end_q   <= ST_RUN;
		end else begin
			trim_q  <= trim_d;
			exp_q   <= exp_d;
			dir_q   <= dir_d;
			match_q <= match_d;
			dcnt_q  <= dcnt_d;
			sum_q   <= sum_d;
			taken_q <= taken_d;
			fin_q   <= fin_d;
			end_q   <= end_d;
		end
	end

endmodule

FILE: rtl/core/resistance_trim_search_top.sv
// ----------------------------------------------------------------------------
// resistance_trim_search_top
// Trim search against a resistance window, one beat in and one beat out.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns exactly one result beat per input beat,
// through an input register and a result register. A start beat clears the search; sample beats are
// summed in runs of sample_count and the last beat of a run carries the
// decision: window compare against (target +/- tolerance) * count, trim step of
// 2^exp and end checks, all in the combinational logic between the input register
// and the result register. Throughput is one beat per cycle as long as the
// result side takes beats. The user must write configuration only while no beat
// is in flight; the block does not check. Writes affect the next accepted beat.
// ----------------------------------------------------------------------------
module resistance_trim_search_top import rts_pkg::*; #(
	parameter int MAX_AVERAGE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [23:0] measured_resistance
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [15:0] trim_value, [17:16] status, [18] done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  adv;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;

	rts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rts_core #(
		.MAX_AVERAGE (MAX_AVERAGE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command <= s_tuser;
			item_s1.meas    <= s_tdata;
		end
		if (adv) begin
			res_q <= res;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the resistance trim search block.
// ----------------------------------------------------------------------------
// A short stimulus list covers the extremes and corner cases. It is followed
// by random search scenarios: convergence, rail runs, decision limit runs and
// free noise. Each scenario may change the registers while the block is idle.
// Every accepted beat goes through a local model of the search. Result beats
// are checked in order against that model, or against the fixed expectation of a
// checked row. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;
	import rts_pkg::*;

	localparam int MAX_AVG  = 16;
	localparam int MEAS_MAX = (1 << MEAS_W) - 1;
	localparam int ITEMS    = 650;

	typedef enum logic [1:0] {ROW_BEAT, ROW_CHECKED, ROW_REG} row_kind_t;
	typedef enum int {CAT_HIT, CAT_HIGH, CAT_LOW, CAT_NOISE} cat_t;
	typedef enum int {SC_CONVERGE, SC_RAIL, SC_LIMIT, SC_FREE} scen_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic        cmd;
		logic [23:0] data;
		res_t        want;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        s_tuser   = CMD_START;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_WIDE_MODE;
	logic [23:0] cfg_data  = '0;

	// typed expectation travelling alongside the current input beat
	logic beat_typed = 1'b0;
	res_t beat_want  = '0;

	// search state and register copies
	logic                     reg_wide     = 1'b0;
	logic [MEAS_W-1:0]        reg_target   = TARGET_RST;
	logic [TOL_W-1:0]         reg_tol      = TOL_RST;
	logic [CNT_W-1:0]         reg_count    = CNT_RST;
	logic signed [TRIM_W-1:0] srch_trim    = '0;
	logic [EXP_W-1:0]         srch_exp     = '0;
	dir_t                     srch_dir     = DIR_NONE;
	logic [MATCH_W-1:0]       srch_hits    = '0;
	logic [DCNT_W-1:0]        srch_decis   = '0;
	logic [28:0]              srch_sum     = '0;
	logic [CNT_W-1:0]         srch_taken   = '0;
	logic                     srch_ended   = 1'b0;
	status_t                  srch_end_st  = ST_RUN;

	res_t trim_expected[$];
	int   mismatches  = 0;
	int   items_sent  = 0;
	int   burst_left  = 0;
	int   rx_style    = 0;
	int   rx_left     = 0;
	int   g_target    = 500000;
	int   g_tol       = 5;
	int   g_need      = 1;

	resistance_trim_search_top #(
		.MAX_AVERAGE(MAX_AVG)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic res_t trim_search_step(logic cmd, logic [MEAS_W-1:0] meas);
		res_t   r;
		int     need, stp, nxt, rail_hi, rail_lo, lim;
		longint lo, hi, sum;
		logic   hit_end;
		hit_end = 1'b0;
		if (cmd == CMD_START) begin
			srch_trim   = '0;
			srch_exp    = reg_wide ? EXP_WIDE_INIT : '0;
			srch_dir    = DIR_NONE;
			srch_hits   = '0;
			srch_decis  = '0;
			srch_sum    = '0;
			srch_taken  = '0;
			srch_ended  = 1'b0;
			srch_end_st = ST_RUN;
		end else if (!srch_ended) begin
			need = (reg_count == 0) ? 1 : (reg_count > MAX_AVG) ? MAX_AVG : int'(reg_count);
			srch_sum   = srch_sum + meas;
			srch_taken = srch_taken + 1'b1;
			if (srch_taken >= need) begin
				lo  = (longint'(reg_target) - longint'(reg_tol)) * longint'(srch_taken);
				hi  = (longint'(reg_target) + longint'(reg_tol)) * longint'(srch_taken);
				sum = longint'(srch_sum);
				rail_hi = reg_wide ? int'(RAIL_HI_WIDE) : int'(RAIL_HI_NARROW);
				rail_lo = reg_wide ? int'(RAIL_LO_WIDE) : int'(RAIL_LO_NARROW);
				lim = reg_wide ? int'(LIMIT_WIDE) : int'(LIMIT_NARROW);
				stp = 1 << srch_exp;
				nxt = int'(srch_trim);
				srch_decis = srch_decis + 1'b1;
				if (sum >= lo && sum <= hi) begin
					if (srch_hits > MATCH_LAST) begin
						srch_ended  = 1'b1;
						srch_end_st = ST_CONVERGED;
						hit_end     = 1'b1;
					end else begin
						srch_hits = srch_hits + 1'b1;
					end
				end else if (sum > hi) begin
					nxt = nxt - stp;
					if (srch_dir == DIR_UP && srch_exp > 0)
						srch_exp = srch_exp - 1'b1;
					srch_dir = DIR_DOWN;
				end else begin
					nxt = nxt + stp;
					if (srch_dir == DIR_DOWN && srch_exp > 0)
						srch_exp = srch_exp - 1'b1;
					srch_dir = DIR_UP;
				end
				if (!hit_end) begin
					if (nxt >= rail_hi || nxt <= rail_lo) begin
						srch_trim   = rail_hi[15:0];
						srch_ended  = 1'b1;
						srch_end_st = ST_RAIL;
					end else begin
						srch_trim = nxt[15:0];
						if (int'(srch_decis) >= lim) begin
							srch_ended  = 1'b1;
							srch_end_st = ST_LIMIT;
						end
					end
				end
				srch_sum   = '0;
				srch_taken = '0;
			end
		end
		r.trim_value = srch_trim;
		r.status     = srch_ended ? srch_end_st : ST_RUN;
		r.done_res   = srch_ended;
		return r;
	endfunction

	// register writes, accepted beats and result checking
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDE_MODE: reg_wide   = cfg_data[0];
				REG_TARGET:    reg_target = cfg_data[MEAS_W-1:0];
				REG_TOLERANCE: reg_tol    = cfg_data[TOL_W-1:0];
				REG_SAMPLES:   reg_count  = cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			want = trim_search_step(s_tuser, s_tdata);
			trim_expected.push_back(beat_typed ? beat_want : want);
		end
		if (m_tvalid && m_tready) begin
			got.trim_value = m_tdata[15:0];
			got.status     = status_t'(m_tdata[17:16]);
			got.done_res   = m_tdata[18];
			if (trim_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: trim %0d status %0d done %0d",
						got.trim_value, got.status, got.done_res);
			end else begin
				want = trim_expected.pop_front();
				if (got.trim_value !== want.trim_value || got.status !== want.status ||
						got.done_res !== want.done_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							want.trim_value, want.status, want.done_res,
							got.trim_value, got.status, got.done_res);
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_left  = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_style)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= ($urandom_range(0, 7) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic send_beat(logic cmd, logic [23:0] d, logic typed, res_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid   <= 1'b1;
		s_tuser    <= cmd;
		s_tdata    <= d;
		beat_typed <= typed;
		beat_want  <= want;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (trim_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(scen_t sc);
		int wide, tgt, tol, cnt;
		wide = $urandom_range(0, 1);
		case ($urandom_range(0, 5))
			0: tgt = 0;
			1: tgt = MEAS_MAX;
			2: tgt = int'(TARGET_RST);
			default: tgt = $urandom_range(0, MEAS_MAX);
		endcase
		case ($urandom_range(0, 5))
			0: tol = 0;
			1: tol = 65535;
			2: tol = 5;
			3: tol = int'(TOL_RST);
			default: tol = $urandom_range(0, 3000);
		endcase
		case ($urandom_range(0, 7))
			0: cnt = 0;
			1: cnt = $urandom_range(16, 31);
			default: cnt = $urandom_range(1, 3);
		endcase
		if (sc == SC_RAIL || sc == SC_LIMIT) begin
			tgt = $urandom_range(100000, MEAS_MAX - 100000);
			tol = $urandom_range(0, 3000);
			cnt = 1;
			if (sc == SC_LIMIT)
				wide = 0;
		end
		write_reg(REG_WIDE_MODE, 24'(wide));
		write_reg(REG_TARGET, tgt[23:0]);
		write_reg(REG_TOLERANCE, tol[23:0]);
		write_reg(REG_SAMPLES, cnt[23:0]);
		g_target = tgt;
		g_tol    = tol;
		g_need   = (cnt == 0) ? 1 : (cnt > MAX_AVG) ? MAX_AVG : cnt;
	endtask

	function automatic logic [23:0] make_sample(cat_t c);
		int lo, hi, v, r;
		lo = g_target - g_tol;
		hi = g_target + g_tol;
		r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEAS_MAX) : $urandom_range(0, 2000);
		case (c)
			CAT_HIT: begin
				if (lo < 0) lo = 0;
				if (hi > MEAS_MAX) hi = MEAS_MAX;
				v = $urandom_range(lo, hi);
			end
			CAT_HIGH: begin
				v = hi + 1 + r;
				if (v > MEAS_MAX) v = MEAS_MAX;
			end
			CAT_LOW: begin
				v = lo - 1 - r;
				if (v < 0) v = 0;
			end
			default: v = $urandom_range(0, MEAS_MAX);
		endcase
		return v[23:0];
	endfunction

	function automatic stim_row_t beat_row(logic cmd, logic [23:0] d);
		stim_row_t r;
		r.kind = ROW_BEAT;
		r.idx  = REG_WIDE_MODE;
		r.cmd  = cmd;
		r.data = d;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic cmd, logic [23:0] d, logic signed [15:0] t,
			status_t st, logic dn);
		stim_row_t r;
		r = beat_row(cmd, d);
		r.kind = ROW_CHECKED;
		r.want.trim_value = t;
		r.want.status     = st;
		r.want.done_res   = dn;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [1:0] idx, logic [23:0] d);
		stim_row_t r;
		r = beat_row(CMD_SAMPLE, d);
		r.kind = ROW_REG;
		r.idx  = idx;
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		scen_t     sc;
		cat_t      cat;
		int        cap, run_left, sent_here, pick;
		logic      up;

		// samples before any start run from the reset state
		rows.push_back(checked_row(CMD_SAMPLE, 24'd500000, 16'sd0, ST_RUN, 1'b0));
		rows.push_back(checked_row(CMD_SAMPLE, 24'd0, 16'sd1, ST_RUN, 1'b0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'hFFFFFF));
		rows.push_back(checked_row(CMD_START, 24'hFFFFFF, 16'sd0, ST_RUN, 1'b0));
		// tolerance above target: negative lower bound
		rows.push_back(reg_row(REG_TOLERANCE, 24'd65535));
		rows.push_back(reg_row(REG_TARGET, 24'd0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'd0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'd65536));
		rows.push_back(reg_row(REG_TARGET, 24'hFFFFFF));
		rows.push_back(reg_row(REG_TOLERANCE, 24'd0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'hFFFFFE));
		// sample count 0 acts as 1
		rows.push_back(reg_row(REG_SAMPLES, 24'd0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'hFFFFFF));
		rows.push_back(reg_row(REG_SAMPLES, 24'd2));
		rows.push_back(beat_row(CMD_SAMPLE, 24'd1000));
		rows.push_back(beat_row(CMD_SAMPLE, 24'd2000));
		rows.push_back(reg_row(REG_WIDE_MODE, 24'd1));
		rows.push_back(reg_row(REG_SAMPLES, 24'd1));
		rows.push_back(reg_row(REG_TARGET, 24'd500000));
		rows.push_back(reg_row(REG_TOLERANCE, 24'd5));
		rows.push_back(checked_row(CMD_START, 24'd0, 16'sd0, ST_RUN, 1'b0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'd0));
		rows.push_back(beat_row(CMD_SAMPLE, 24'hFFFFFF));
		// eleventh hit ends the search; trim is back at 0 here
		repeat (11) rows.push_back(beat_row(CMD_SAMPLE, 24'd500000));
		rows.push_back(checked_row(CMD_SAMPLE, 24'd123, 16'sd0, ST_CONVERGED, 1'b1));

		wait (arst_n);
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_REG: begin
					wait_idle();
					write_reg(rows[i].idx, rows[i].data);
				end
				ROW_CHECKED: send_beat(rows[i].cmd, rows[i].data, 1'b1, rows[i].want);
				default: send_beat(rows[i].cmd, rows[i].data, 1'b0, '0);
			endcase
		end

		while (items_sent < ITEMS) begin
			sc = scen_t'($urandom_range(0, 3));
			wait_idle();
			if (sc != SC_FREE || $urandom_range(0, 4) != 0)
				set_config(sc);
			// a free run without start keeps the search going across a register change
			if (sc != SC_FREE || $urandom_range(0, 5) != 0)
				send_beat(CMD_START, make_sample(CAT_NOISE), 1'b0, '0);
			case (sc)
				SC_CONVERGE: cap = 200;
				SC_FREE:     cap = 60;
				default:     cap = 160;
			endcase
			run_left  = 0;
			sent_here = 0;
			up        = $urandom_range(0, 1);
			cat       = CAT_HIT;
			while (!srch_ended && sent_here < cap && items_sent < ITEMS) begin
				if (run_left == 0) begin
					run_left = g_need;
					pick = $urandom_range(0, 9);
					case (sc)
						SC_CONVERGE: cat = (pick < 8) ? CAT_HIT : (pick == 8) ? CAT_HIGH : CAT_LOW;
						SC_RAIL:     cat = up ? CAT_LOW : CAT_HIGH;
						SC_LIMIT: begin
							up  = ~up;
							cat = up ? CAT_LOW : CAT_HIGH;
						end
						default:     cat = cat_t'($urandom_range(0, 3));
					endcase
				end
				if (sc == SC_FREE && $urandom_range(0, 49) == 0)
					send_beat(CMD_START, make_sample(CAT_NOISE), 1'b0, '0);
				else
					send_beat(CMD_SAMPLE, make_sample(cat), 1'b0, '0);
				run_left--;
				sent_here++;
			end
			repeat ($urandom_range(0, 3))
				send_beat(CMD_SAMPLE, make_sample(CAT_NOISE), 1'b0, '0);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && trim_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
